// File: src/rgbabx_pkg.sv
// Shared types, constants and channel arithmetic for the 2x2 RGBA box downsampler.
// Depends on nothing; the top level and its checker refer to it by scoped names.
`default_nettype none

package rgbabx_pkg;

  localparam int CH_NUM  = 4;
  localparam int CH_W    = 8;
  localparam int SUM_W   = CH_W + 1;
  localparam int PIXEL_W = CH_NUM * CH_W;
  localparam int LINE_W  = CH_NUM * SUM_W;
  localparam int REG_W   = 12;
  localparam int ADDR_W  = 1;

  typedef logic [PIXEL_W-1:0] pixel_t;
  typedef logic [LINE_W-1:0]  pair_sum_t;
  typedef logic [REG_W-1:0]   size_reg_t;

  // Register indexes on the configuration port
  localparam logic [ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam size_reg_t SIZE_RESET = 12'd256;

  // Per-channel sums of two pixels, 9-bit fields, alpha on top.
  function automatic pair_sum_t pair_sums(input pixel_t p, input pixel_t q);
    pair_sum_t packed_sum;
    packed_sum = '0;
    for (int ch = 0; ch < CH_NUM; ch++) begin
      packed_sum[ch*SUM_W +: SUM_W] = {1'b0, p[ch*CH_W +: CH_W]} + {1'b0, q[ch*CH_W +: CH_W]};
    end
    return packed_sum;
  endfunction

  // Add two pair-sum words per channel and divide by four, truncating.
  function automatic pixel_t average_block(input pair_sum_t upper, input pair_sum_t lower);
    pixel_t           avg;
    logic [SUM_W:0]   s;
    avg = '0;
    for (int ch = 0; ch < CH_NUM; ch++) begin
      s = {1'b0, upper[ch*SUM_W +: SUM_W]} + {1'b0, lower[ch*SUM_W +: SUM_W]};
      avg[ch*CH_W +: CH_W] = s[SUM_W:2];
    end
    return avg;
  endfunction

endpackage

`default_nettype wire

// File: src/rgba_box_downsample_2x2.sv
// Top level of the 2x2 box-filter downsampler for packed RGBA pixels.
// Depends on rgbabx_pkg for types, register indexes and channel arithmetic.
//
// Usage:
//   Feed pixels of an image in raster order on the s_ stream, one word per
//   clock at most. Every 2x2 block gives one averaged word on the m_ stream;
//   m_tlast marks the final word of the image. Program image_width (index 0)
//   and image_height (index 1) through cfg_we/cfg_addr/cfg_wdata while idle;
//   sizes are taken even, clamped to 2..MAX_WIDTH and 2..MAX_HEIGHT.
//   Throughput: one input word per clock unless stalled. An even row writes
//   per-pair channel sums into the line memory (one write port); an odd row
//   reads them back (one registered read port) and emits one word per pair.
//   The right pixel of an odd-row pair starts a registered memory read; the
//   averaged word then goes into the output register.
//   Reset (rst, synchronous) clears counters, the pipeline and sets both
//   sizes to 256. The line memory is not cleared: even rows fill it before
//   odd rows read it.
//   Stall: a waiting output word holds; the stage behind it keeps one more
//   word, and s_tready drops only when both are full.
`default_nettype none

module rgba_box_downsample_2x2 #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  wire                                clk,
  input  wire                                rst,
  // input pixel stream
  input  wire                                s_tvalid,
  output logic                               s_tready,
  input  wire  [rgbabx_pkg::PIXEL_W-1:0]     s_tdata,   // [31:0] pixel_in
  // averaged pixel stream
  output logic                               m_tvalid,
  input  wire                                m_tready,
  output logic [rgbabx_pkg::PIXEL_W-1:0]     m_tdata,   // [31:0] pixel_out
  output logic                               m_tlast,   // last_out
  // configuration writes
  input  wire                                cfg_we,
  input  wire  [rgbabx_pkg::ADDR_W-1:0]      cfg_addr,
  input  wire  [rgbabx_pkg::REG_W-1:0]       cfg_wdata
);

  localparam int CW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW    = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DEPTH = MAX_WIDTH / 2;
  localparam int SW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // compare widths: wide enough for the register and for the size limit
  localparam int EWW   = (CW + 2 > rgbabx_pkg::REG_W) ? CW + 2 : rgbabx_pkg::REG_W;
  localparam int EHW   = (RW + 2 > rgbabx_pkg::REG_W) ? RW + 2 : rgbabx_pkg::REG_W;

  // configuration registers
  rgbabx_pkg::size_reg_t image_width;
  rgbabx_pkg::size_reg_t image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= rgbabx_pkg::SIZE_RESET;
      image_height <= rgbabx_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        rgbabx_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_wdata;
        rgbabx_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective sizes: drop bit 0, clamp to the supported range
  logic [EWW-1:0] width_even;
  logic [EWW-1:0] width_eff;
  logic [EHW-1:0] height_even;
  logic [EHW-1:0] height_eff;

  always_comb begin
    width_even  = EWW'({image_width[rgbabx_pkg::REG_W-1:1], 1'b0});
    height_even = EHW'({image_height[rgbabx_pkg::REG_W-1:1], 1'b0});
    if (width_even < EWW'(2))              width_eff = EWW'(2);
    else if (width_even > EWW'(MAX_WIDTH)) width_eff = EWW'(MAX_WIDTH);
    else                                   width_eff = width_even;
    if (height_even < EHW'(2))               height_eff = EHW'(2);
    else if (height_even > EHW'(MAX_HEIGHT)) height_eff = EHW'(MAX_HEIGHT);
    else                                     height_eff = height_even;
  end

  // position counters and left pixel of the current pair
  logic [CW-1:0]          col;
  logic [RW-1:0]          row;
  rgbabx_pkg::pixel_t     left_pixel;

  logic                   accept;
  logic                   row_end;
  logic                   image_end;
  logic                   odd_col;
  logic                   odd_row;
  logic [SW-1:0]          slot;
  rgbabx_pkg::pair_sum_t  sums;
  logic                   wr_en;
  logic                   rd_en;

  assign accept    = s_tvalid && s_tready;
  assign row_end   = (EWW'(col) + EWW'(1)) >= width_eff;
  assign image_end = row_end && ((EHW'(row) + EHW'(1)) >= height_eff);
  assign odd_col   = col[0];
  assign odd_row   = row[0];
  assign slot      = SW'(col >> 1);
  assign sums      = rgbabx_pkg::pair_sums(left_pixel, s_tdata);
  assign wr_en     = accept && odd_col && !odd_row;
  assign rd_en     = accept && odd_col && odd_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      col        <= '0;
      row        <= '0;
      left_pixel <= '0;
    end else if (accept) begin
      // hold the left pixel of each pair until its partner arrives
      if (!odd_col) begin
        left_pixel <= s_tdata;
      end
      if (row_end) begin
        col <= '0;
        row <= image_end ? '0 : row + RW'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  // line memory of pair sums from the even row; registered read
  rgbabx_pkg::pair_sum_t pair_sum_line [DEPTH];
  rgbabx_pkg::pair_sum_t rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pair_sum_line[slot] <= sums;
    end
  end

  // the read word holds while the stage behind it is stalled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= pair_sum_line[slot];
    end
  end

  // stage 1: lower pair sums wait for the memory word
  logic                  p1_valid;
  rgbabx_pkg::pair_sum_t p1_lower;
  logic                  p1_last;
  logic                  p1_move;

  // advance stage 1 when the output register is empty or draining
  assign p1_move  = p1_valid && (!m_tvalid || m_tready);
  // accept unless both stage 1 and the output register hold a word
  assign s_tready = !p1_valid || !m_tvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (rd_en) begin
      p1_valid <= 1'b1;
    end else if (p1_move) begin
      p1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      p1_lower <= sums;
      p1_last  <= image_end;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (p1_move) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_move) begin
      m_tdata <= rgbabx_pkg::average_block(rd_data, p1_lower);
      m_tlast <= p1_last;
    end
  end

endmodule

`default_nettype wire

// File: src/rgbabx_check.sv
// Port-level checker for the 2x2 RGBA box downsampler, bound to the top level.
// Depends on rgbabx_pkg for the pixel width.
`default_nettype none

module rgbabx_check (
  input wire                             clk,
  input wire                             rst,
  input wire                             s_tvalid,
  input wire                             s_tready,
  input wire                             m_tvalid,
  input wire                             m_tready,
  input wire [rgbabx_pkg::PIXEL_W-1:0]   m_tdata,
  input wire                             m_tlast
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word valid right after reset");

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  // with the output register empty the input side is always ready
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // a new output word must have a matching accepted input word earlier
  a_out_from_in: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("output word without matching input word");

endmodule

bind rgba_box_downsample_2x2 rgbabx_check u_rgbabx_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire
